/* rtl/ssnr_pkg.sv */
// Shared types and constants for the segmental SNR meter.
`timescale 1ns / 1ps
`default_nettype none
package ssnr_pkg;
    localparam int SAMPLE_BITS      = 16;
    localparam int MAX_FRAME_LENGTH = 1024;
    localparam int CFG_BITS         = 11;
    localparam int HALF_BITS        = $clog2(MAX_FRAME_LENGTH / 2);
    localparam int ENERGY_BITS      = 48;
    localparam int TOTAL_BITS       = 32;
    localparam int COUNT_BITS       = 16;
    localparam int DB_BITS          = 16;
    localparam logic [ENERGY_BITS-1:0] ENERGY_MAX = '1;
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
    localparam logic [DB_BITS-1:0]     DB_LIMIT   = 16'd32767;
    localparam logic [25:0]            LOG_SCALE  = 26'd50504453;
    localparam logic [CFG_BITS-1:0]    FRAME_LENGTH_RESET = 11'd256;

    // controller -> datapath commands
    typedef struct packed {
        logic acc;        // accumulate the accepted sample
        logic frame_start; // start per-frame dB computation
        logic mean_start;  // start the mean division
        logic clear;       // clear stream state
    } ssnr_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic frame_done;
        logic mean_done;
        logic frame_due;   // accumulation just closed a full frame
    } ssnr_sts_t;
endpackage
`default_nettype wire

/* rtl/ssnr_dpath.sv */
// Datapath of the segmental SNR meter: accumulators, log unit, divider.
`timescale 1ns / 1ps
`default_nettype none
module ssnr_dpath import ssnr_pkg::*; (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [CFG_BITS-1:0]           frame_length,
    input  wire logic signed [SAMPLE_BITS-1:0] clean_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] noisy_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] enhanced_sample,
    input  wire ssnr_cmd_t                     cmd,
    output ssnr_sts_t                          sts,
    output logic signed [DB_BITS-1:0]          noisy_mean,
    output logic signed [DB_BITS-1:0]          enhanced_mean,
    output logic [COUNT_BITS-1:0]              count_out
);
    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int SQ_BITS   = 2 * DIFF_BITS;

    logic [HALF_BITS-1:0]   half_reg;
    logic                   second_reg;
    logic [ENERGY_BITS-1:0] ce_reg [2];
    logic [ENERGY_BITS-1:0] ne_reg [2];
    logic [ENERGY_BITS-1:0] ee_reg [2];
    logic signed [TOTAL_BITS-1:0] nt_reg, et_reg;
    logic [COUNT_BITS-1:0]  cnt_reg;
    // snapshot of the closed frame
    logic [ENERGY_BITS-1:0] fc_reg, fn_reg, fe_reg;

    // sample squares
    logic signed [DIFF_BITS-1:0] c_d, n_d, e_d;
    logic [DIFF_BITS-1:0] c_m, n_m, e_m;
    logic [SQ_BITS-1:0] c_sq, n_sq, e_sq;
    logic [CFG_BITS-1:0] len;
    logic [HALF_BITS-1:0] hop_m1;
    logic wrap;

    always_comb begin
        c_d = DIFF_BITS'(clean_sample);
        n_d = DIFF_BITS'(noisy_sample) - c_d;
        e_d = DIFF_BITS'(enhanced_sample) - c_d;
        c_m = c_d[DIFF_BITS-1] ? DIFF_BITS'(-c_d) : DIFF_BITS'(c_d);
        n_m = n_d[DIFF_BITS-1] ? DIFF_BITS'(-n_d) : DIFF_BITS'(n_d);
        e_m = e_d[DIFF_BITS-1] ? DIFF_BITS'(-e_d) : DIFF_BITS'(e_d);
        c_sq = c_m * c_m;
        n_sq = n_m * n_m;
        e_sq = e_m * e_m;
        len = frame_length;
        if (len < CFG_BITS'(2)) len = CFG_BITS'(2);
        if (len > CFG_BITS'(MAX_FRAME_LENGTH)) len = CFG_BITS'(MAX_FRAME_LENGTH);
        hop_m1 = HALF_BITS'((len >> 1) - CFG_BITS'(1));
        wrap = (half_reg >= hop_m1);
    end

    function automatic logic [ENERGY_BITS-1:0] sat_add(
        input logic [ENERGY_BITS-1:0] a, input logic [SQ_BITS-1:0] b);
        logic [ENERGY_BITS:0] s;
        s = {1'b0, a} + (ENERGY_BITS + 1)'(b);
        return s[ENERGY_BITS] ? ENERGY_MAX : s[ENERGY_BITS-1:0];
    endfunction

    // log / dB sequencer state
    typedef enum logic [3:0] {
        L_IDLE = 4'b0001, L_NORM = 4'b0010, L_SQ = 4'b0100, L_MUL = 4'b1000
    } lstate_t;
    lstate_t ls_reg;
    logic [1:0]  job_reg;     // 0: clean, 1: noisy err, 2: enhanced err
    logic [5:0]  p_reg;
    logic [ENERGY_BITS-1:0] x_reg;
    logic [31:0] m_reg;
    logic [4:0]  it_reg;
    logic [15:0] fr_reg;
    logic [21:0] lc_reg, ln_reg;   // log2 in Q6.16
    logic        mphase_reg;
    logic        sq_phase_reg;
    logic [63:0] sq_reg;
    logic signed [DB_BITS-1:0] dbn_reg;
    logic [1:0]  mjob_reg;
    logic [47:0] prod_reg;
    logic        fdone_reg;

    // Scale the log difference product down by 2^32, rounding the magnitude half up.
    function automatic logic signed [DB_BITS-1:0] to_db(input logic [47:0] prod,
                                                         input logic neg);
        logic [16:0] mag;
        logic [48:0] r;
        r = {1'b0, prod} + 49'h0_8000_0000;
        mag = (r[48:32] > 17'(DB_LIMIT)) ? 17'(DB_LIMIT) : r[48:32];
        return neg ? DB_BITS'(-mag) : DB_BITS'(mag);
    endfunction

    logic signed [22:0] dlog;
    logic [21:0] dmag;
    always_comb begin
        dlog = $signed({1'b0, lc_reg}) - $signed({1'b0, ln_reg});
        dmag = dlog[22] ? 22'(-dlog) : 22'(dlog);
    end

    // mean divider: restoring, one quotient bit a cycle
    logic        dv_busy_reg;
    logic [5:0]  dv_it_reg;
    logic [31:0] dv_q_reg;
    logic [32:0] dv_r_reg;
    logic [31:0] dv_n_reg;
    logic        dv_neg_reg, dv_sel_reg, mdone_reg;
    logic [32:0] dv_trial;
    logic [31:0] nt_mag, et_mag;
    always_comb begin
        nt_mag = nt_reg[TOTAL_BITS-1] ? 32'(-nt_reg) : 32'(nt_reg);
        et_mag = et_reg[TOTAL_BITS-1] ? 32'(-et_reg) : 32'(et_reg);
        dv_trial = {dv_r_reg[31:0], dv_n_reg[31]};
    end

    always_ff @(posedge aclk) begin
        fdone_reg <= 1'b0;
        mdone_reg <= 1'b0;
        if (!aresetn || cmd.clear) begin
            half_reg <= '0; second_reg <= 1'b0;
            for (int k = 0; k < 2; k++) begin
                ce_reg[k] <= '0; ne_reg[k] <= '0; ee_reg[k] <= '0;
            end
            nt_reg <= '0; et_reg <= '0; cnt_reg <= '0;
            if (!aresetn) begin
                ls_reg <= L_IDLE; dv_busy_reg <= 1'b0;
            end
        end else begin
            if (cmd.acc) begin
                for (int k = 0; k < 2; k++) begin
                    if (k == 0 || second_reg) begin
                        ce_reg[k] <= sat_add(ce_reg[k], c_sq);
                        ne_reg[k] <= sat_add(ne_reg[k], n_sq);
                        ee_reg[k] <= sat_add(ee_reg[k], e_sq);
                    end
                end
                if (wrap) begin
                    half_reg <= '0;
                    if (second_reg) begin
                        // hand off the closed frame; advance the newer set
                        fc_reg <= sat_add(ce_reg[0], c_sq);
                        fn_reg <= sat_add(ne_reg[0], n_sq);
                        fe_reg <= sat_add(ee_reg[0], e_sq);
                        ce_reg[0] <= sat_add(ce_reg[1], c_sq);
                        ne_reg[0] <= sat_add(ne_reg[1], n_sq);
                        ee_reg[0] <= sat_add(ee_reg[1], e_sq);
                        ce_reg[1] <= '0; ne_reg[1] <= '0; ee_reg[1] <= '0;
                    end else second_reg <= 1'b1;
                end else half_reg <= half_reg + HALF_BITS'(1);
            end
            // per-frame dB: three log2 evaluations (clean, noisy, enhanced)
            case (ls_reg)
                L_IDLE: if (cmd.frame_start) begin
                    if (cnt_reg == COUNT_MAX) fdone_reg <= 1'b1;
                    else begin
                        job_reg <= 2'd0; x_reg <= fc_reg;
                        p_reg <= '0; ls_reg <= L_NORM;
                    end
                end
                L_NORM: begin
                    if (p_reg < 6'd63 && (x_reg >> (p_reg + 6'd1)) != '0)
                        p_reg <= p_reg + 6'd1;
                    else begin
                        m_reg <= (p_reg > 6'd30) ? 32'(x_reg >> (p_reg - 6'd30))
                                                 : 32'(x_reg << (6'd30 - p_reg));
                        it_reg <= '0; fr_reg <= '0; sq_phase_reg <= 1'b0;
                        ls_reg <= L_SQ;
                    end
                end
                L_SQ: begin
                    if (!sq_phase_reg) begin
                        sq_reg <= m_reg * m_reg;
                        sq_phase_reg <= 1'b1;
                    end else begin
                        sq_phase_reg <= 1'b0;
                        if (sq_reg[61]) begin
                            fr_reg <= {fr_reg[14:0], 1'b1};
                            m_reg <= 32'(sq_reg >> 31);
                        end else begin
                            fr_reg <= {fr_reg[14:0], 1'b0};
                            m_reg <= 32'(sq_reg >> 30);
                        end
                        it_reg <= it_reg + 5'd1;
                        if (it_reg == 5'd15) begin
                            ls_reg <= L_MUL; mphase_reg <= 1'b0;
                        end
                    end
                end
                L_MUL: begin
                    if (job_reg == 2'd0) begin
                        lc_reg <= {p_reg, fr_reg};
                        job_reg <= 2'd1; x_reg <= fn_reg; p_reg <= '0;
                        ls_reg <= L_NORM;
                    end else if (!mphase_reg) begin
                        ln_reg <= {p_reg, fr_reg};
                        mphase_reg <= 1'b1;
                    end else if (mjob_reg != job_reg) begin
                        prod_reg <= 48'(dmag) * 48'(LOG_SCALE);
                        mjob_reg <= job_reg;
                    end else begin
                        if (job_reg == 2'd1) begin
                            if (fn_reg == '0) dbn_reg <= DB_LIMIT;
                            else if (fc_reg == '0) dbn_reg <= -DB_LIMIT;
                            else dbn_reg <= to_db(prod_reg, dlog[22]);
                            job_reg <= 2'd2; x_reg <= fe_reg; p_reg <= '0;
                            ls_reg <= L_NORM;
                        end else begin
                            nt_reg <= nt_reg + TOTAL_BITS'(dbn_reg);
                            if (fe_reg == '0) et_reg <= et_reg + TOTAL_BITS'(DB_LIMIT);
                            else if (fc_reg == '0)
                                et_reg <= et_reg - TOTAL_BITS'(DB_LIMIT);
                            else et_reg <= et_reg + TOTAL_BITS'(to_db(prod_reg, dlog[22]));
                            cnt_reg <= cnt_reg + COUNT_BITS'(1);
                            fdone_reg <= 1'b1; ls_reg <= L_IDLE;
                        end
                        mjob_reg <= 2'd3; mphase_reg <= 1'b0;
                    end
                end
                default: ls_reg <= L_IDLE;
            endcase
            if (ls_reg == L_IDLE && cmd.frame_start) mjob_reg <= 2'd3;
            // mean: noisy then enhanced, magnitude rounded half up
            if (cmd.mean_start) begin
                dv_busy_reg <= 1'b1; dv_sel_reg <= 1'b0; dv_it_reg <= '0;
                dv_r_reg <= '0; dv_q_reg <= '0;
                dv_n_reg <= nt_mag + 32'(cnt_reg >> 1);
                dv_neg_reg <= nt_reg[TOTAL_BITS-1];
            end else if (dv_busy_reg) begin
                if (dv_trial >= 33'(cnt_reg)) begin
                    dv_r_reg <= dv_trial - 33'(cnt_reg);
                    dv_q_reg <= {dv_q_reg[30:0], 1'b1};
                end else begin
                    dv_r_reg <= dv_trial;
                    dv_q_reg <= {dv_q_reg[30:0], 1'b0};
                end
                dv_n_reg <= {dv_n_reg[30:0], 1'b0};
                dv_it_reg <= dv_it_reg + 6'd1;
                if (dv_it_reg == 6'd32) begin
                    dv_it_reg <= '0; dv_r_reg <= '0; dv_q_reg <= '0;
                    if (!dv_sel_reg) begin
                        noisy_mean <= dv_neg_reg ? DB_BITS'(-dv_q_reg) : DB_BITS'(dv_q_reg);
                        dv_sel_reg <= 1'b1;
                        dv_n_reg <= et_mag + 32'(cnt_reg >> 1);
                        dv_neg_reg <= et_reg[TOTAL_BITS-1];
                    end else begin
                        enhanced_mean <= dv_neg_reg ? DB_BITS'(-dv_q_reg)
                                                    : DB_BITS'(dv_q_reg);
                        dv_busy_reg <= 1'b0; mdone_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign count_out      = cnt_reg;
    assign sts.frame_done = fdone_reg;
    assign sts.mean_done  = mdone_reg;
    assign sts.frame_due  = cmd.acc && wrap && second_reg;
endmodule
`default_nettype wire

/* rtl/ssnr_ctrl.sv */
// Controller of the segmental SNR meter: sequences accumulate, frame and mean work.
`timescale 1ns / 1ps
`default_nettype none
module ssnr_ctrl import ssnr_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire logic      last_sample,
    output logic           m_valid,
    input  wire logic      m_ready,
    output ssnr_cmd_t      cmd,
    input  wire ssnr_sts_t sts,
    output logic           load_out
);
    typedef enum logic [4:0] {
        S_RUN   = 5'b00001,
        S_FRAME = 5'b00010,
        S_MEAN  = 5'b00100,
        S_OUT   = 5'b01000,
        S_START = 5'b10000
    } state_t;
    state_t state_reg, state_next;
    logic   last_reg, last_next;
    logic   mv_reg, mv_next;
    logic   busy_reg, busy_next;   // never set; stays low from reset
    logic   acc;

    assign s_ready  = (state_reg == S_RUN) && !busy_reg;
    assign acc      = s_valid && s_ready;
    assign m_valid  = mv_reg;

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        mv_next    = mv_reg && !m_ready;
        busy_next  = busy_reg;
        cmd        = '0;
        load_out   = 1'b0;
        cmd.acc    = acc;
        case (state_reg)
            S_RUN: if (acc) begin
                last_next = last_sample;
                if (sts.frame_due) state_next = S_START;
                else if (last_sample) state_next = S_MEAN;
            end
            S_START: begin
                cmd.frame_start = 1'b1;
                state_next = S_FRAME;
            end
            S_FRAME: if (sts.frame_done) begin
                state_next = last_reg ? S_MEAN : S_RUN;
            end
            S_MEAN: if (!mv_reg) begin
                cmd.mean_start = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: if (sts.mean_done) begin
                load_out  = 1'b1;
                mv_next   = 1'b1;
                cmd.clear = 1'b1;
                state_next = S_RUN;
            end
            default: state_next = S_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RUN; last_reg <= 1'b0; mv_reg <= 1'b0; busy_reg <= 1'b0;
        end else begin
            state_reg <= state_next; last_reg <= last_next;
            mv_reg <= mv_next; busy_reg <= busy_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/segmental_snr_meter_top.sv */
// Top level of the segmental SNR meter.
`timescale 1ns / 1ps
`default_nettype none
// Segmental SNR meter. Each transfer on the s_ channel carries one clean, noisy
// and enhanced sample; frames of frame_length samples start every half frame.
// An ordinary sample never holds the input. A sample that closes a full frame holds
// the input while the shared log2 unit works out the frame's dB values: for each
// of three energies it normalizes one bit a cycle up to the energy's leading one,
// then runs 16 squaring iterations, and then scales and adds. The sample marked
// last additionally runs a one-bit-a-cycle divider for both means and then posts
// one result transfer on m_; the next stream may start while that result waits,
// but a second result waits until the first is taken. The user must write
// frame_length through cfg_valid/cfg_ready only while the block is idle; the block
// itself does not enforce it. frame_length resets to 256.
module segmental_snr_meter_top import ssnr_pkg::*; (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_BITS-1:0]           cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_clean_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] s_noisy_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] s_enhanced_sample,
    input  wire logic                          s_last_sample,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [DB_BITS-1:0]          m_noisy_ssnr_db,
    output logic signed [DB_BITS-1:0]          m_enhanced_ssnr_db,
    output logic [COUNT_BITS-1:0]              m_frames_used
);
    logic [CFG_BITS-1:0] flen_reg;
    ssnr_cmd_t cmd;
    ssnr_sts_t sts;
    logic load;
    logic signed [DB_BITS-1:0] nm, em;
    logic [COUNT_BITS-1:0] cnt;

    // Config register: always writable.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) flen_reg <= FRAME_LENGTH_RESET;
        else if (cfg_valid) flen_reg <= cfg_data;
    end

    ssnr_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .last_sample(s_last_sample),
        .m_valid, .m_ready, .cmd, .sts, .load_out(load)
    );

    ssnr_dpath u_dpath (
        .aclk, .aresetn, .frame_length(flen_reg),
        .clean_sample(s_clean_sample), .noisy_sample(s_noisy_sample),
        .enhanced_sample(s_enhanced_sample), .cmd, .sts,
        .noisy_mean(nm), .enhanced_mean(em), .count_out(cnt)
    );

    // Output register: hold the result until its transfer; zero frames gives zeros.
    always_ff @(posedge aclk) begin
        if (load) begin
            m_frames_used      <= cnt;
            m_noisy_ssnr_db    <= (cnt == '0) ? '0 : nm;
            m_enhanced_ssnr_db <= (cnt == '0) ? '0 : em;
        end
    end
endmodule
`default_nettype wire

/* rtl/ssnr_checker.sv */
// Port-level checker for the segmental SNR meter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ssnr_checker import ssnr_pkg::*; (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic [COUNT_BITS-1:0] m_frames_used,
    input wire logic signed [DB_BITS-1:0] m_noisy_ssnr_db
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frames_used))
        else $error("result dropped or changed while stalled");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frames_used == '0 |-> m_noisy_ssnr_db == '0)
        else $error("nonzero mean with no frames");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
    a_last_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && m_valid && !m_ready |=> m_valid)
        else $error("pending result lost on input transfer");
endmodule

bind segmental_snr_meter_top ssnr_checker u_ssnr_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_frames_used, .m_noisy_ssnr_db
);
`default_nettype wire

/* tb/tb_top.sv */
// Testbench for the segmental SNR meter: random and directed sample streams checked against a built-in predictor.
`timescale 1ns / 1ps
`default_nettype none

// Predictor of per-stream SNR averages and queue of pending results.
class ssnr_scoreboard;
    typedef struct {
        logic signed [15:0] noisy_db;
        logic signed [15:0] enhanced_db;
        logic [15:0]        frames;
    } ssnr_result_t;

    ssnr_result_t  pending[$];
    int            errors;
    logic [10:0]   frame_len;
    int unsigned   half_pos;
    bit            second_set;
    logic [47:0]   clean_e[2];
    logic [47:0]   noisy_e[2];
    logic [47:0]   enh_e[2];
    longint        noisy_sum;
    longint        enh_sum;
    int unsigned   frame_cnt;

    function new();
        errors    = 0;
        frame_len = ssnr_pkg::FRAME_LENGTH_RESET;
        clear_stream();
    endfunction

    function void clear_stream();
        half_pos   = 0;
        second_set = 0;
        for (int k = 0; k < 2; k++) begin
            clean_e[k] = '0;
            noisy_e[k] = '0;
            enh_e[k]   = '0;
        end
        noisy_sum = 0;
        enh_sum   = 0;
        frame_cnt = 0;
    endfunction

    function logic [47:0] energy_add(logic [47:0] a, longint unsigned b);
        longint unsigned s;
        s = longint'(a) + b;
        return (s > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    // log2 as integer part * 65536 plus 16 truncated fraction bits
    function longint log2_fixed(longint unsigned x);
        int unsigned     p;
        longint unsigned m;
        int unsigned     fr;
        p  = 0;
        fr = 0;
        while (p < 63 && (x >> (p + 1)) != 0) p++;
        m = (p > 30) ? (x >> (p - 30)) : (x << (30 - p));
        for (int i = 0; i < 16; i++) begin
            m  = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (64'd1 << 31)) begin
                fr = fr | 1;
                m  = m >> 1;
            end
        end
        return longint'(p) * 65536 + fr;
    endfunction

    function longint frame_snr(logic [47:0] cl, logic [47:0] er);
        longint          d;
        longint unsigned mag;
        if (er == 0) return 32767;
        if (cl == 0) return -32767;
        d   = log2_fixed(cl) - log2_fixed(er);
        mag = longint'(d < 0 ? -d : d) * 64'd50504453;
        mag = (mag + (64'd1 << 31)) >> 32;
        if (mag > 32767) mag = 32767;
        return d < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function logic [15:0] rounded_mean(longint total, int unsigned n);
        longint unsigned mag;
        mag = total < 0 ? -total : total;
        mag = (mag + n / 2) / n;
        return total < 0 ? -mag[15:0] : mag[15:0];
    endfunction

    // Note one accepted input transfer and predict its result, if any.
    function void note_sample(logic signed [15:0] c, logic signed [15:0] n,
                              logic signed [15:0] e, bit last);
        longint          cv, dn, de;
        longint unsigned ce, ne, ee;
        int unsigned     len, hop;
        ssnr_result_t    r;
        cv  = c;
        dn  = longint'(n) - cv;
        de  = longint'(e) - cv;
        ce  = cv * cv;
        ne  = dn * dn;
        ee  = de * de;
        len = frame_len;
        if (len < 2) len = 2;
        if (len > 1024) len = 1024;
        len = len & ~1;
        hop = len / 2;
        for (int k = 0; k < (second_set ? 2 : 1); k++) begin
            clean_e[k] = energy_add(clean_e[k], ce);
            noisy_e[k] = energy_add(noisy_e[k], ne);
            enh_e[k]   = energy_add(enh_e[k], ee);
        end
        if (half_pos >= hop - 1) begin
            half_pos = 0;
            if (second_set) begin
                if (frame_cnt < 65535) begin
                    noisy_sum += frame_snr(clean_e[0], noisy_e[0]);
                    enh_sum   += frame_snr(clean_e[0], enh_e[0]);
                    frame_cnt++;
                end
                clean_e[0] = clean_e[1];
                noisy_e[0] = noisy_e[1];
                enh_e[0]   = enh_e[1];
                clean_e[1] = '0;
                noisy_e[1] = '0;
                enh_e[1]   = '0;
            end else begin
                second_set = 1;
            end
        end else begin
            half_pos++;
        end
        if (!last) return;
        if (frame_cnt == 0) begin
            r.noisy_db = '0;
            r.enhanced_db = '0;
            r.frames = '0;
        end else begin
            r.noisy_db    = rounded_mean(noisy_sum, frame_cnt);
            r.enhanced_db = rounded_mean(enh_sum, frame_cnt);
            r.frames      = frame_cnt[15:0];
        end
        pending.push_back(r);
        clear_stream();
    endfunction

    // Compare one result transfer against the oldest prediction.
    function void check_result(logic signed [15:0] nd, logic signed [15:0] ed,
                               logic [15:0] fu);
        ssnr_result_t r;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result noisy=%0d enhanced=%0d frames=%0d",
                     $time, nd, ed, fu);
            errors++;
            return;
        end
        r = pending.pop_front();
        if (nd !== r.noisy_db) begin
            $display("%0t: noisy_ssnr_db expected %0d actual %0d", $time, r.noisy_db, nd);
            errors++;
        end
        if (ed !== r.enhanced_db) begin
            $display("%0t: enhanced_ssnr_db expected %0d actual %0d",
                     $time, r.enhanced_db, ed);
            errors++;
        end
        if (fu !== r.frames) begin
            $display("%0t: frames_used expected %0d actual %0d", $time, r.frames, fu);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import ssnr_pkg::*;

    logic                          aclk = 0;
    logic                          aresetn = 0;
    logic                          cfg_valid = 0;
    logic                          cfg_ready;
    logic [CFG_BITS-1:0]           cfg_data = '0;
    logic                          s_valid = 0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_clean_sample = '0;
    logic signed [SAMPLE_BITS-1:0] s_noisy_sample = '0;
    logic signed [SAMPLE_BITS-1:0] s_enhanced_sample = '0;
    logic                          s_last_sample = 0;
    logic                          m_valid;
    logic                          m_ready = 0;
    logic signed [DB_BITS-1:0]     m_noisy_ssnr_db;
    logic signed [DB_BITS-1:0]     m_enhanced_ssnr_db;
    logic [COUNT_BITS-1:0]         m_frames_used;

    localparam longint CYCLE_LIMIT = 4_000_000;

    ssnr_scoreboard sb = new();
    int     send_idle_pct = 0;   // percent chance the sender idles per cycle
    int     recv_stall_pct = 0;  // percent chance the receiver stalls per cycle
    int     hold_off_cycles = 0; // long receiver hold-off, counted down below
    longint cycle_count = 0;

    segmental_snr_meter_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_clean_sample(s_clean_sample), .s_noisy_sample(s_noisy_sample),
        .s_enhanced_sample(s_enhanced_sample), .s_last_sample(s_last_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_noisy_ssnr_db(m_noisy_ssnr_db), .m_enhanced_ssnr_db(m_enhanced_ssnr_db),
        .m_frames_used(m_frames_used)
    );

    always #10 aclk = ~aclk;

    // Stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sample results at the rising edge; check every completed transfer.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_noisy_ssnr_db, m_enhanced_ssnr_db, m_frames_used);
    end

    // Drive ready at the falling edge: a long hold-off wins over random stalls.
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one sample transfer and wait until it is accepted; valid drops
    // only when the sender idles or pauses.
    task automatic send_sample(logic signed [15:0] c, logic signed [15:0] n,
                               logic signed [15:0] e, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid           <= 1;
        s_clean_sample    <= c;
        s_noisy_sample    <= n;
        s_enhanced_sample <= e;
        s_last_sample     <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(c, n, e, last);
        @(negedge aclk);
    endtask

    // Drop valid, hold until every expected result has arrived, then let the block settle.
    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    // Write frame_length while the block is idle.
    task automatic write_frame_length(logic [CFG_BITS-1:0] len);
        drain();
        cfg_valid <= 1;
        cfg_data  <= len;
        do @(posedge aclk); while (!cfg_ready);
        sb.frame_len = len;
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    // Send one stream of random samples: moderate, wild, tiny or zero-error noise per stream.
    task automatic send_stream(int n_samples);
        logic signed [15:0] c, n, e;
        int mode;
        mode = $urandom_range(3);
        for (int i = 0; i < n_samples; i++) begin
            c = 16'($urandom);
            case (mode)
                0: begin
                    n = c + $signed(16'($urandom_range(0, 2000)) - 16'sd1000);
                    e = c + $signed(16'($urandom_range(0, 60)) - 16'sd30);
                end
                1: begin
                    n = 16'($urandom);
                    e = 16'($urandom);
                end
                2: begin
                    n = c;
                    e = c ^ 16'($urandom_range(1));
                end
                default: begin
                    c = ($urandom_range(3) == 0) ? 16'sd0 : c;
                    n = 16'($urandom);
                    e = c;
                end
            endcase
            send_sample(c, n, e, i == n_samples - 1);
        end
    endtask

    initial begin
        int sent;
        repeat (2) @(negedge aclk);
        aresetn <= 1;

        // Directed: reset length of 256, extremes, zero-error and zero-clean frames.
        for (int i = 0; i < 3; i++) send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 0);
        send_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 1);   // no full frame
        write_frame_length(11'd2);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh8000, 0);
        send_sample(16'sh8000, 16'sh8000, 16'sh7FFF, 0);
        send_sample(16'sh0000, 16'sh1234, 16'sh0000, 0);
        send_sample(16'sh0000, -16'sh1234, 16'sh0000, 0);
        send_sample(16'sh5555, 16'shAAAA, 16'sh5554, 1);   // frame ends on last
        send_sample(16'sh0001, 16'sh0002, 16'sh0003, 1);
        write_frame_length(11'd0);                         // clamps up to 2
        send_stream(6);
        write_frame_length(11'd7);                         // odd, rounds down to 6
        send_stream(13);
        // Clamp to 1024: one half frame of 512 opens the second set, then a
        // short hop closes the first frame right away.
        write_frame_length(11'd2047);
        for (int i = 0; i < 512; i++)
            send_sample(16'($urandom), 16'($urandom), 16'($urandom), 0);
        write_frame_length(11'd4);
        send_stream(6);

        // Random phases with different idling profiles and frame lengths.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            write_frame_length(11'($urandom_range(1, 8) * 2 + (ph == 1 ? 1 : 0)));
            if (ph == 2) hold_off_cycles = 3000;  // block fills and stalls input
            sent = 0;
            while (sent < 90) begin
                int len;
                len = $urandom_range(1, 40);
                send_stream(len);
                sent += len;
            end
            if (ph == 3) drain();  // sender pauses until all results are in
        end
        // Mid-stream length change: hop shrinks under a running half frame.
        write_frame_length(11'd16);
        send_stream(1);
        for (int i = 0; i < 5; i++) send_sample(16'($urandom), 16'($urandom), 16'($urandom), 0);
        write_frame_length(11'd4);
        send_stream(9);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
rtl/ssnr_pkg.sv
rtl/ssnr_dpath.sv
rtl/ssnr_ctrl.sv
rtl/segmental_snr_meter_top.sv
rtl/ssnr_checker.sv
tb/tb_top.sv
